### rtl/core/ipv4hv_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hv_pkg
// types and constants shared by the ipv4 header validator modules
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hv_pkg;

    localparam int unsigned IDX_W      = 6;
    localparam int unsigned NOP_W      = 7;

    localparam logic [IDX_W-1:0] MIN_HDR_LEN   = 6'd20;
    localparam logic [IDX_W-1:0] POS_VERSION   = 6'd0;
    localparam logic [IDX_W-1:0] POS_TOTAL_LO  = 6'd3;
    localparam logic [IDX_W-1:0] POS_TTL       = 6'd8;
    localparam logic [3:0]       IP_VERSION    = 4'd4;
    localparam logic [15:0]      SUM_ALL_ONES  = 16'hFFFF;
    localparam logic [7:0]       OPT_TYPE_EOL  = 8'd0;
    localparam logic [7:0]       OPT_TYPE_NOP  = 8'd1;
    localparam logic [7:0]       OPT_MIN_LEN   = 8'd2;

    localparam logic CFG_CHECK_CHECKSUM = 1'b0;
    localparam logic CFG_CHECK_OPTIONS  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_VERSION  = 3'd1,
        STATUS_BAD_HDR_SIZE = 3'd2,
        STATUS_BAD_TOT_SIZE = 3'd3,
        STATUS_EXPIRED      = 3'd4,
        STATUS_BAD_CHECKSUM = 3'd5,
        STATUS_BAD_OPTIONS  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        OPT_EXPECT_TYPE = 4'b0001,
        OPT_EXPECT_LEN  = 4'b0010,
        OPT_END_SEEN    = 4'b0100,
        OPT_MALFORMED   = 4'b1000
    } opt_phase_t;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] expected_length;
        status_t          first_error;
        logic [15:0]      sum;
        logic [7:0]       held_high_byte;
        logic [NOP_W-1:0] next_opt_pos;
        opt_phase_t       opt_phase;
    } hv_state_t;

endpackage

`default_nettype wire

### rtl/core/ipv4hv_step.sv
// ----------------------------------------------------------------------------
// ipv4hv_step
// next-state and status logic for one header byte
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_step (
    input  wire ipv4hv_pkg::hv_state_t cur,
    input  wire logic [7:0]            header_byte,
    input  wire logic                  first_byte,
    input  wire logic                  check_checksum,
    input  wire logic                  check_options,
    output ipv4hv_pkg::hv_state_t      nxt,
    output logic                       emit,
    output ipv4hv_pkg::status_t        status
);
    import ipv4hv_pkg::*;

    hv_state_t        base;
    logic             active;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] hl;
    status_t          code;
    logic [15:0]      word;
    logic [16:0]      sum17;
    logic [8:0]       opt_end;
    logic [IDX_W:0]   p_plus1;
    logic             final_byte;

    always_comb
    begin
        base = cur;
        if (first_byte)
        begin
            base.byte_index     = '0;
            base.first_error    = STATUS_OK;
            base.sum            = '0;
            base.held_high_byte = '0;
            base.next_opt_pos   = {1'b0, MIN_HDR_LEN};
            base.opt_phase      = OPT_EXPECT_TYPE;
        end
        active = first_byte || (cur.byte_index != '0);
        p      = base.byte_index;
        nxt    = base;
        hl     = {header_byte[3:0], 2'b00};
        code   = STATUS_OK;
        word   = {base.held_high_byte, header_byte};
        sum17  = {1'b0, base.sum} + {1'b0, word};
        opt_end = {2'b00, base.next_opt_pos} + {1'b0, header_byte};

        // field checks
        if (p == POS_VERSION)
        begin
            if (header_byte[7:4] != IP_VERSION)
                code = STATUS_BAD_VERSION;
            else if (hl < MIN_HDR_LEN)
                code = STATUS_BAD_HDR_SIZE;
            nxt.expected_length = (hl < MIN_HDR_LEN) ? MIN_HDR_LEN : hl;
        end
        else if (p == POS_TOTAL_LO)
        begin
            if (word < {10'd0, base.expected_length})
                code = STATUS_BAD_TOT_SIZE;
        end
        else if (p == POS_TTL)
        begin
            if (header_byte == 8'd0)
                code = STATUS_EXPIRED;
        end
        if (base.first_error == STATUS_OK)
            nxt.first_error = code;

        // ones-complement sum with end-around carry
        if (p[0])
            nxt.sum = sum17[15:0] + {15'd0, sum17[16]};
        else
            nxt.held_high_byte = header_byte;

        // option walk
        if (p >= MIN_HDR_LEN)
        begin
            case (base.opt_phase)
                OPT_EXPECT_TYPE:
                begin
                    if ({1'b0, p} == base.next_opt_pos)
                    begin
                        if (header_byte == OPT_TYPE_EOL)
                            nxt.opt_phase = OPT_END_SEEN;
                        else if (header_byte == OPT_TYPE_NOP)
                            nxt.next_opt_pos = {1'b0, p} + 7'd1;
                        else
                            nxt.opt_phase = OPT_EXPECT_LEN;
                    end
                end
                OPT_EXPECT_LEN:
                begin
                    if (header_byte < OPT_MIN_LEN
                        || opt_end > {3'd0, nxt.expected_length})
                        nxt.opt_phase = OPT_MALFORMED;
                    else
                    begin
                        nxt.next_opt_pos = opt_end[NOP_W-1:0];
                        nxt.opt_phase    = OPT_EXPECT_TYPE;
                    end
                end
                default:
                begin
                    nxt.opt_phase = base.opt_phase;
                end
            endcase
        end

        // end of header
        p_plus1    = {1'b0, p} + 7'd1;
        final_byte = p_plus1 >= {1'b0, nxt.expected_length};
        status     = nxt.first_error;
        if (status == STATUS_OK && check_checksum && nxt.sum != SUM_ALL_ONES)
            status = STATUS_BAD_CHECKSUM;
        if (status == STATUS_OK && check_options
            && (nxt.opt_phase == OPT_EXPECT_LEN || nxt.opt_phase == OPT_MALFORMED))
            status = STATUS_BAD_OPTIONS;
        nxt.byte_index = final_byte ? '0 : p_plus1[IDX_W-1:0];
        emit = active && final_byte;

        if (!active)
        begin
            nxt  = cur;
            emit = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipv4_header_validator_core.sv
// ----------------------------------------------------------------------------
// ipv4_header_validator_core
// validates an ipv4 header streamed one byte per transfer
// ----------------------------------------------------------------------------
// usage:
//   s_* carries header bytes in network order; tuser high marks byte 0 and
//   restarts the header. the block takes max(20, ihl*4) bytes and then sends
//   one status transfer on m_*: ok, bad version, bad header size, bad total
//   size, expired, bad checksum or malformed options.
//   cfg_* writes the two check enables (index 0 checksum, index 1 options);
//   write them only while no header is in flight. cfg_ready is always high.
// timing:
//   one byte per cycle sustained while the output is not stalled; each byte
//   goes through an input register and a single pass of update logic, and
//   the status is registered in the output register before it is on m_tvalid.
// reset:
//   rst_n low empties both registers, clears the walk state and sets both
//   check enables.
// stall:
//   with m_tready low and a status waiting, the input register holds its
//   byte and s_tready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_validator_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] header_byte
    input  wire logic       s_tuser,   // [0] first_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [2:0] status, [7:3] zero
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data
);
    import ipv4hv_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    logic [7:0] in_byte_reg;
    logic      in_first_reg;
    hv_state_t state_reg;
    hv_state_t state_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    status_t   out_status_reg;
    status_t   step_status;
    logic      step_emit;
    logic      check_checksum_reg;
    logic      check_options_reg;
    logic      advance;
    logic      fire;
    logic      s_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_status_reg};

    ipv4hv_step u_step (
        .cur            (state_reg),
        .header_byte    (in_byte_reg),
        .first_byte     (in_first_reg),
        .check_checksum (check_checksum_reg),
        .check_options  (check_options_reg),
        .nxt            (state_next),
        .emit           (step_emit),
        .status         (step_status)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = fire && step_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg          <= '{byte_index: '0, expected_length: '0,
                                    first_error: STATUS_OK, sum: '0,
                                    held_high_byte: '0, next_opt_pos: '0,
                                    opt_phase: OPT_EXPECT_TYPE};
            check_checksum_reg <= 1'b1;
            check_options_reg  <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CHECK_CHECKSUM)
                    check_checksum_reg <= cfg_data;
                else
                    check_options_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (fire && step_emit)
            out_status_reg <= step_status;
    end

endmodule

`default_nettype wire
